[sv/ps2mt_pkg.sv]
package ps2mt_pkg;

	// configuration register width and reset values
	localparam int CFG_BITS = 10;
	localparam logic [CFG_BITS-1:0] X_MIN_RST = 10'd0;
	localparam logic [CFG_BITS-1:0] X_MAX_RST = 10'd639;
	localparam logic [CFG_BITS-1:0] Y_MIN_RST = 10'd0;
	localparam logic [CFG_BITS-1:0] Y_MAX_RST = 10'd199;

	// pointer position after reset
	localparam int X_START = 320;
	localparam int Y_START = 100;

	// header byte layout
	localparam logic [7:0] HDR_SYNC_MASK = 8'hC0;
	localparam int HDR_XSIGN_BIT = 4;
	localparam int HDR_YSIGN_BIT = 5;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_X_MIN = 2'd0,
		REG_X_MAX = 2'd1,
		REG_Y_MIN = 2'd2,
		REG_Y_MAX = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] x_min;
		logic [CFG_BITS-1:0] x_max;
		logic [CFG_BITS-1:0] y_min;
		logic [CFG_BITS-1:0] y_max;
	} window_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} mouse_item_t;

	typedef struct packed {
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
		logic [6:0]  cell_x;
		logic [6:0]  cell_y;
		logic [2:0]  buttons;
		logic [15:0] left_presses;
		logic [15:0] left_releases;
		logic [15:0] right_presses;
		logic [15:0] right_releases;
	} report_item_t;

	// one assembled three-byte packet
	typedef struct packed {
		logic [7:0] header;
		logic [7:0] dx_byte;
		logic [7:0] dy_byte;
	} packet_t;

endpackage

[sv/ps2mt_stream_if.sv]
interface ps2mt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/ps2mt_assembler.sv]
module ps2mt_assembler (
	input  logic                clk,
	input  logic                arst_n,
	ps2mt_stream_if.sink        mouse,
	input  logic                pkt_ready,
	output ps2mt_pkg::packet_t  pkt_s1,
	output logic                pkt_valid_s1
);
	import ps2mt_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DX,
		PH_DY
	} phase_t;

	phase_t     phase_q;
	logic [7:0] header_q;
	logic [7:0] dx_q;
	logic       accept;

	// a byte is taken whenever the packet slot is free or draining
	assign mouse.ready = !pkt_valid_s1 || pkt_ready;
	assign accept      = mouse.valid && mouse.ready;

	// byte sequencer and packet register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			pkt_valid_s1 <= 1'b0;
			pkt_s1       <= '0;
			header_q     <= '0;
			dx_q         <= '0;
		end else begin
			// slot fills on a third byte, empties when the tracker takes it
			pkt_valid_s1 <= (accept && (phase_q == PH_DY)) || (pkt_valid_s1 && !pkt_ready);
			if (accept) begin
				unique case (phase_q)
					PH_HEADER: begin
						// only a byte with both top bits clear opens a packet
						if ((mouse.data.data_byte & HDR_SYNC_MASK) == 8'h00) begin
							header_q <= mouse.data.data_byte;
							phase_q  <= PH_DX;
						end
					end
					PH_DX: begin
						dx_q    <= mouse.data.data_byte;
						phase_q <= PH_DY;
					end
					PH_DY: begin
						pkt_s1.header  <= header_q;
						pkt_s1.dx_byte <= dx_q;
						pkt_s1.dy_byte <= mouse.data.data_byte;
						phase_q        <= PH_HEADER;
					end
					default: begin
						phase_q <= PH_HEADER;
					end
				endcase
			end
		end
	end
endmodule

[sv/ps2mt_tracker.sv]
module ps2mt_tracker #(
	parameter int POS_BITS   = 10,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ps2mt_pkg::packet_t  pkt_s1,
	input  logic                pkt_valid_s1,
	output logic                pkt_ready,
	input  ps2mt_pkg::window_t  window,
	ps2mt_stream_if.source      report
);
	import ps2mt_pkg::*;

	localparam int SW = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 2;

	logic [POS_BITS-1:0]   cur_x_q;
	logic [POS_BITS-1:0]   cur_y_q;
	logic [2:0]            btn_q;
	logic [COUNT_BITS-1:0] lp_q, lr_q, rp_q, rr_q;
	logic                  rpt_valid_q;

	logic                  advance;
	logic signed [9:0]     dx;
	logic signed [9:0]     dy;
	logic [POS_BITS-1:0]   nxt_x;
	logic [POS_BITS-1:0]   nxt_y;
	logic [2:0]            nxt_btn;
	logic [9:0]            pos_x10;
	logic [9:0]            pos_y10;

	// add a delta and clamp to the window, limits taken in either order
	function automatic logic [POS_BITS-1:0] clamp_axis(
		input logic [POS_BITS-1:0] cur,
		input logic signed [9:0]   delta,
		input logic [CFG_BITS-1:0] a,
		input logic [CFG_BITS-1:0] b
	);
		logic signed [SW-1:0] lo;
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] v;
		lo = signed'(SW'((a < b) ? a : b));
		hi = signed'(SW'((a < b) ? b : a));
		v  = signed'(SW'(cur)) + SW'(delta);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return POS_BITS'(v);
	endfunction

	assign pkt_ready = !rpt_valid_q || report.ready;
	assign advance   = pkt_valid_s1 && pkt_ready;

	// packet decode: 9-bit signed deltas, dy negated for screen space
	always_comb begin
		dx      = 10'(signed'({pkt_s1.header[HDR_XSIGN_BIT], pkt_s1.dx_byte}));
		dy      = -10'(signed'({pkt_s1.header[HDR_YSIGN_BIT], pkt_s1.dy_byte}));
		nxt_x   = clamp_axis(cur_x_q, dx, window.x_min, window.x_max);
		nxt_y   = clamp_axis(cur_y_q, dy, window.y_min, window.y_max);
		nxt_btn = pkt_s1.header[2:0];
	end

	// pointer state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= POS_BITS'(X_START);
			cur_y_q     <= POS_BITS'(Y_START);
			btn_q       <= '0;
			lp_q        <= '0;
			lr_q        <= '0;
			rp_q        <= '0;
			rr_q        <= '0;
			rpt_valid_q <= 1'b0;
		end else begin
			rpt_valid_q <= advance || (rpt_valid_q && !report.ready);
			if (advance) begin
				cur_x_q     <= nxt_x;
				cur_y_q     <= nxt_y;
				btn_q       <= nxt_btn;
				// left and right edges; middle is reported only
				if (nxt_btn[0] && !btn_q[0]) lp_q <= lp_q + COUNT_BITS'(1);
				if (!nxt_btn[0] && btn_q[0]) lr_q <= lr_q + COUNT_BITS'(1);
				if (nxt_btn[1] && !btn_q[1]) rp_q <= rp_q + COUNT_BITS'(1);
				if (!nxt_btn[1] && btn_q[1]) rr_q <= rr_q + COUNT_BITS'(1);
			end
		end
	end

	assign pos_x10 = 10'(cur_x_q);
	assign pos_y10 = 10'(cur_y_q);

	assign report.valid               = rpt_valid_q;
	assign report.data.pos_x          = pos_x10;
	assign report.data.pos_y          = pos_y10;
	assign report.data.cell_x         = pos_x10[9:3];
	assign report.data.cell_y         = pos_y10[9:3];
	assign report.data.buttons        = btn_q;
	assign report.data.left_presses   = 16'(lp_q);
	assign report.data.left_releases  = 16'(lr_q);
	assign report.data.right_presses  = 16'(rp_q);
	assign report.data.right_releases = 16'(rr_q);
endmodule

[sv/ps2_mouse_packet_tracker.sv]
// PS/2 mouse packet tracker. Raw mouse bytes enter on the mouse channel, one
// byte per transaction; a byte can be taken in every cycle unless the packet
// register is stalled. A packet opens only on a byte with both top bits clear;
// the next two bytes close it whatever their value. Each completed packet gives
// one report transaction carrying the clamped pointer position, its text cell
// (position / 8), the buttons and left/right press and release counts, and
// passes the packet register, then the result register. The window registers
// (x_min, x_max, y_min, y_max; a min above its max is taken swapped) are set
// via cfg_we/cfg_index/cfg_data by the user only while idle; not enforced here.
module ps2_mouse_packet_tracker #(
	parameter int POS_BITS   = 10,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [ps2mt_pkg::CFG_BITS-1:0]    cfg_data,
	ps2mt_stream_if.sink                      mouse,
	ps2mt_stream_if.source                    report
);
	import ps2mt_pkg::*;

	window_t window_q;
	packet_t pkt_s1;
	logic    pkt_valid_s1;
	logic    pkt_ready;

	// window configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q.x_min <= X_MIN_RST;
			window_q.x_max <= X_MAX_RST;
			window_q.y_min <= Y_MIN_RST;
			window_q.y_max <= Y_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_X_MIN: window_q.x_min <= cfg_data;
				REG_X_MAX: window_q.x_max <= cfg_data;
				REG_Y_MIN: window_q.y_min <= cfg_data;
				REG_Y_MAX: window_q.y_max <= cfg_data;
				default: ;
			endcase
		end
	end

	ps2mt_assembler u_assembler (
		.clk          (clk),
		.arst_n       (arst_n),
		.mouse        (mouse),
		.pkt_ready    (pkt_ready),
		.pkt_s1       (pkt_s1),
		.pkt_valid_s1 (pkt_valid_s1)
	);

	ps2mt_tracker #(
		.POS_BITS   (POS_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.pkt_s1       (pkt_s1),
		.pkt_valid_s1 (pkt_valid_s1),
		.pkt_ready    (pkt_ready),
		.window       (window_q),
		.report       (report)
	);
endmodule

[sv/ps2mt_checker.sv]
module ps2mt_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      report_valid,
	input  logic                      report_ready,
	input  ps2mt_pkg::report_item_t   report_data
);
	import ps2mt_pkg::*;

	logic        seen_q;
	logic [15:0] lp_q;
	logic [15:0] rr_q;

	// remember counts of the last delivered report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			lp_q   <= '0;
			rr_q   <= '0;
		end else if (report_valid && report_ready) begin
			seen_q <= 1'b1;
			lp_q   <= report_data.left_presses;
			rr_q   <= report_data.right_releases;
		end
	end

	// a stalled report stays and holds its payload
	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> report_valid && $stable(report_data))
		else $error("report dropped or changed while stalled");

	// text cell follows the position
	a_cell_match: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> report_data.cell_x == report_data.pos_x[9:3] &&
			report_data.cell_y == report_data.pos_y[9:3])
		else $error("text cell does not match position");

	// one packet adds at most one press per button
	a_lp_step: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_ready && seen_q |->
			report_data.left_presses == lp_q ||
			report_data.left_presses == lp_q + 16'd1)
		else $error("left press count jumped");

	a_rr_step: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_ready && seen_q |->
			report_data.right_releases == rr_q ||
			report_data.right_releases == rr_q + 16'd1)
		else $error("right release count jumped");
endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.report_valid (report.valid),
	.report_ready (report.ready),
	.report_data  (report.data)
);
